>>> sv/spc_pkg.sv
package spc_pkg;

    localparam int COORD_W       = 32;
    localparam int MAX_VERTS_DEF = 8;
    localparam int FRAC_BITS_DEF = 16;
    // Wide enough for a vertex count at the largest supported store depth.
    localparam int CNT_MAX_W     = 7;

    typedef enum logic [1:0] {
        REQ_VERT_A = 2'd0,
        REQ_VERT_B = 2'd1,
        REQ_CENT_A = 2'd2,
        REQ_START  = 2'd3
    } req_t;

    typedef struct packed {
        logic [CNT_MAX_W-1:0]      cnt_a;
        logic [CNT_MAX_W-1:0]      cnt_b;
        logic                      ovf;
        logic signed [COORD_W-1:0] ca_x;
        logic signed [COORD_W-1:0] ca_y;
        logic signed [COORD_W-1:0] cb_x;
        logic signed [COORD_W-1:0] cb_y;
    } job_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FETCH0,
        S_FETCH1,
        S_DIFF,
        S_NORM,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_DIV,
        S_AXIS,
        S_PADDR,
        S_PMUL,
        S_PACC,
        S_CMP,
        S_SCMUL,
        S_SCSUM,
        S_DIRMUL,
        S_DIR,
        S_DONE
    } back_state_t;

endpackage

>>> sv/spc_if.sv
interface spc_item_if;
    logic                                      valid;
    logic                                      ready;
    logic [1:0]                                req_type;
    logic signed [spc_pkg::COORD_W-1:0]        coord_x;
    logic signed [spc_pkg::COORD_W-1:0]        coord_y;

    modport source (output valid, output req_type, output coord_x, output coord_y,
                    input ready);
    modport sink   (input valid, input req_type, input coord_x, input coord_y,
                    output ready);
endinterface

interface spc_result_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      intersects;
    logic signed [spc_pkg::COORD_W-1:0]        mtv_x;
    logic signed [spc_pkg::COORD_W-1:0]        mtv_y;
    logic                                      overflow;

    modport source (output valid, output intersects, output mtv_x, output mtv_y,
                    output overflow, input ready);
    modport sink   (input valid, input intersects, input mtv_x, input mtv_y,
                    input overflow, output ready);
endinterface

>>> sv/sat_polygon_collision.sv
// Vertex and centroid beats are taken one per cycle; vertex beats wait while a test is queued or running.
// A start beat is taken while the job queue has room; its result follows after the axis walk.
// Each axis walk runs through the 32-step square root, the FRAC_BITS + 1 step divide and an address,
// multiply and accumulate step per projection; the final scaling and direction test follow the last axis,
// and an early miss ends the walk at once.
// Reset clears the vertex counts, the centroid, the job queue and the output valid; vertex stores are not cleared.
module sat_polygon_collision #(
    parameter int MAX_VERTS = spc_pkg::MAX_VERTS_DEF,
    parameter int FRAC_BITS = spc_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    spc_item_if.sink     item,
    spc_result_if.source result
);

    localparam int AW = $clog2(MAX_VERTS);

    logic          q_push, q_pop, q_full, q_empty, back_busy;
    spc_pkg::job_t q_in, q_out;
    logic          we_a, we_b;
    logic [AW-1:0] waddr_a, waddr_b, raddr;
    logic [63:0]   wdata, rdata_a, rdata_b;

    spc_front #(.MAX_VERTS(MAX_VERTS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .back_busy (back_busy),
        .q_full    (q_full),
        .q_empty   (q_empty),
        .q_push    (q_push),
        .q_job     (q_in),
        .we_a      (we_a),
        .we_b      (we_b),
        .waddr_a   (waddr_a),
        .waddr_b   (waddr_b),
        .wdata     (wdata)
    );

    spc_ram #(.WIDTH(64), .DEPTH(MAX_VERTS)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    spc_ram #(.WIDTH(64), .DEPTH(MAX_VERTS)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    spc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .pop   (q_pop),
        .dout  (q_out),
        .full  (q_full),
        .empty (q_empty)
    );

    spc_back #(.MAX_VERTS(MAX_VERTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (q_out),
        .q_pop   (q_pop),
        .busy    (back_busy),
        .raddr   (raddr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .result  (result)
    );

endmodule

>>> sv/spc_ram.sv
module spc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/spc_front.sv
module spc_front #(
    parameter int MAX_VERTS = spc_pkg::MAX_VERTS_DEF,
    localparam int AW       = $clog2(MAX_VERTS),
    localparam int CW       = $clog2(MAX_VERTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    spc_item_if.sink      item,
    input  logic          back_busy,
    input  logic          q_full,
    input  logic          q_empty,
    output logic          q_push,
    output spc_pkg::job_t q_job,
    output logic          we_a,
    output logic          we_b,
    output logic [AW-1:0] waddr_a,
    output logic [AW-1:0] waddr_b,
    output logic [63:0]   wdata
);

    spc_pkg::req_t req;
    logic          busy;
    logic          acc;
    logic          full_a;
    logic          full_b;

    logic [CW-1:0]        cnt_a_reg, cnt_a_next;
    logic [CW-1:0]        cnt_b_reg, cnt_b_next;
    logic                 ovf_reg, ovf_next;
    logic signed [31:0]   ca_x_reg, ca_x_next;
    logic signed [31:0]   ca_y_reg, ca_y_next;

    assign req    = spc_pkg::req_t'(item.req_type);
    // The vertex stores are read by the back end until its job is finished.
    assign busy   = back_busy || !q_empty;
    assign full_a = (cnt_a_reg == CW'(MAX_VERTS));
    assign full_b = (cnt_b_reg == CW'(MAX_VERTS));

    always_comb
    begin
        case (req)
            spc_pkg::REQ_VERT_A, spc_pkg::REQ_VERT_B: item.ready = !busy;
            spc_pkg::REQ_CENT_A:                      item.ready = 1'b1;
            spc_pkg::REQ_START:                       item.ready = !q_full;
            default:                                  item.ready = 1'b0;
        endcase
    end

    assign acc     = item.valid && item.ready;
    assign we_a    = acc && (req == spc_pkg::REQ_VERT_A) && !full_a;
    assign we_b    = acc && (req == spc_pkg::REQ_VERT_B) && !full_b;
    assign waddr_a = AW'(cnt_a_reg);
    assign waddr_b = AW'(cnt_b_reg);
    assign wdata   = {item.coord_x, item.coord_y};

    assign q_push     = acc && (req == spc_pkg::REQ_START);
    assign q_job.cnt_a = spc_pkg::CNT_MAX_W'(cnt_a_reg);
    assign q_job.cnt_b = spc_pkg::CNT_MAX_W'(cnt_b_reg);
    assign q_job.ovf   = ovf_reg;
    assign q_job.ca_x  = ca_x_reg;
    assign q_job.ca_y  = ca_y_reg;
    assign q_job.cb_x  = item.coord_x;
    assign q_job.cb_y  = item.coord_y;

    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        ca_x_next  = ca_x_reg;
        ca_y_next  = ca_y_reg;
        if (acc)
        begin
            case (req)
                spc_pkg::REQ_VERT_A:
                begin
                    if (full_a)
                        ovf_next = 1'b1;
                    else
                        cnt_a_next = cnt_a_reg + CW'(1);
                end
                spc_pkg::REQ_VERT_B:
                begin
                    if (full_b)
                        ovf_next = 1'b1;
                    else
                        cnt_b_next = cnt_b_reg + CW'(1);
                end
                spc_pkg::REQ_CENT_A:
                begin
                    ca_x_next = item.coord_x;
                    ca_y_next = item.coord_y;
                end
                spc_pkg::REQ_START:
                begin
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ovf_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
            ca_x_reg  <= '0;
            ca_y_reg  <= '0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ovf_reg   <= ovf_next;
            ca_x_reg  <= ca_x_next;
            ca_y_reg  <= ca_y_next;
        end
    end

endmodule

>>> sv/spc_fifo.sv
module spc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spc_pkg::job_t din,
    input  logic          pop,
    output spc_pkg::job_t dout,
    output logic          full,
    output logic          empty
);

    spc_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("job pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("job popped from an empty queue");

endmodule

>>> sv/spc_back.sv
module spc_back #(
    parameter int MAX_VERTS = spc_pkg::MAX_VERTS_DEF,
    parameter int FRAC_BITS = spc_pkg::FRAC_BITS_DEF,
    localparam int AW       = $clog2(MAX_VERTS),
    localparam int CW       = $clog2(MAX_VERTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  spc_pkg::job_t q_job,
    output logic          q_pop,
    output logic          busy,
    output logic [AW-1:0] raddr,
    input  logic [63:0]   rdata_a,
    input  logic [63:0]   rdata_b,
    spc_result_if.source  result
);

    localparam int NW  = FRAC_BITS + 2;         // signed axis component
    localparam int UW  = FRAC_BITS + 1;         // axis magnitude
    localparam int MW  = 32 + NW;               // one projection product
    localparam int PW  = 34 + NW;               // projections and overlaps
    localparam int HW  = PW - 1 - FRAC_BITS + UW;
    localparam int LW  = FRAC_BITS + UW;
    localparam int SW  = HW + 1;
    localparam int RW  = SW - FRAC_BITS;
    localparam int SQ_STEPS = 32;
    localparam logic [RW-1:0] R_MAX     = RW'(64'h7FFF_FFFF);
    localparam logic [RW-1:0] R_MIN_MAG = RW'(64'h8000_0000);
    localparam logic [UW-1:0] Q_ONE     = UW'(1) << FRAC_BITS;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        neg_sat = (v == S32_MIN) ? S32_MAX : -v;
    endfunction

    spc_pkg::back_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    logic [CW-1:0]        cnt_a_reg, cnt_a_next;
    logic [CW-1:0]        cnt_b_reg, cnt_b_next;
    logic                 ovf_reg, ovf_next;
    logic signed [31:0]   ca_x_reg, ca_x_next, ca_y_reg, ca_y_next;
    logic signed [31:0]   cb_x_reg, cb_x_next, cb_y_reg, cb_y_next;
    logic                 edge_b_reg, edge_b_next;
    logic [AW-1:0]        edge_idx_reg, edge_idx_next;
    logic                 first_axis_reg, first_axis_next;
    logic [63:0]          p0_reg, p0_next;
    logic                 dx_neg_reg, dx_neg_next, dy_neg_reg, dy_neg_next;
    logic [32:0]          ax_reg, ax_next, ay_reg, ay_next;
    logic [61:0]          sqx_reg, sqx_next;
    logic [62:0]          rem_reg, rem_next, root_reg, root_next, bit_reg, bit_next;
    logic [4:0]           step_reg, step_next;
    logic [33:0]          drx_reg, drx_next, dry_reg, dry_next;
    logic [UW-1:0]        qx_reg, qx_next, qy_reg, qy_next;
    logic signed [NW-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic                 proj_b_reg, proj_b_next;
    logic [AW-1:0]        proj_idx_reg, proj_idx_next;
    logic signed [MW-1:0] pmx_reg, pmx_next, pmy_reg, pmy_next;
    logic signed [PW-1:0] alo_reg, alo_next, ahi_reg, ahi_next;
    logic signed [PW-1:0] blo_reg, blo_next, bhi_reg, bhi_next;
    logic signed [PW-1:0] best_reg, best_next;
    logic signed [NW-1:0] bnx_reg, bnx_next, bny_reg, bny_next;
    logic                 comp_reg, comp_next;
    logic [HW-1:0]        shi_reg, shi_next;
    logic [LW-1:0]        slo_reg, slo_next;
    logic signed [31:0]   mx_reg, mx_next, my_reg, my_next;
    logic signed [64:0]   pdx_reg, pdx_next, pdy_reg, pdy_next;
    logic                 hit_reg, hit_next;
    logic                 o_hit_reg, o_hit_next, o_ovf_reg, o_ovf_next;
    logic signed [31:0]   o_mx_reg, o_mx_next, o_my_reg, o_my_next;

    logic [63:0]          sel_data;
    logic [CW-1:0]        edge_n, edge_inc, proj_n, proj_inc;
    logic                 edge_wrap, last_axis, proj_wrap;
    logic [AW-1:0]        j_idx;
    logic signed [32:0]   dx, dy;
    logic [32:0]          dx_abs, dy_abs;
    logic                 zero_edge;
    logic [61:0]          ay_sq;
    logic [62:0]          sq_try;
    logic [33:0]          len34, tx, ty;
    logic                 bx, by;
    logic signed [31:0]   pvx, pvy;
    logic signed [PW-1:0] pv;
    logic signed [PW-1:0] ov, ov_hi, ov_lo;
    logic                 sep;
    logic signed [NW-1:0] sc_c;
    logic [UW-1:0]        sc_m;
    logic [PW-2:0]        u_ov;
    logic [SW-1:0]        sc_full;
    logic [RW-1:0]        sc_r;
    logic signed [31:0]   sc_val;
    logic signed [32:0]   dcx, dcy;
    logic signed [65:0]   dsum;
    logic                 load_out;

    // ---------------------------------------------------------------
    // Shared combinational terms
    // ---------------------------------------------------------------
    assign sel_data  = edge_b_reg ? rdata_b : rdata_a;
    assign edge_n    = edge_b_reg ? cnt_b_reg : cnt_a_reg;
    assign edge_inc  = CW'(edge_idx_reg) + CW'(1);
    assign edge_wrap = (edge_inc == edge_n);
    assign j_idx     = edge_wrap ? '0 : AW'(edge_inc);
    assign last_axis = edge_b_reg && edge_wrap;
    assign proj_n    = proj_b_reg ? cnt_b_reg : cnt_a_reg;
    assign proj_inc  = CW'(proj_idx_reg) + CW'(1);
    assign proj_wrap = (proj_inc == proj_n);

    assign dx        = $signed({p0_reg[63], p0_reg[63:32]})
                     - $signed({sel_data[63], sel_data[63:32]});
    assign dy        = $signed({p0_reg[31], p0_reg[31:0]})
                     - $signed({sel_data[31], sel_data[31:0]});
    assign dx_abs    = dx[32] ? 33'(-dx) : 33'(dx);
    assign dy_abs    = dy[32] ? 33'(-dy) : 33'(dy);
    assign zero_edge = (dx == '0) && (dy == '0);

    assign ay_sq     = ay_reg[30:0] * ay_reg[30:0];
    assign sq_try    = root_reg + bit_reg;

    assign len34     = {2'b00, root_reg[31:0]};
    assign tx        = (step_reg == '0) ? drx_reg : {drx_reg[32:0], 1'b0};
    assign ty        = (step_reg == '0) ? dry_reg : {dry_reg[32:0], 1'b0};
    assign bx        = (tx >= len34);
    assign by        = (ty >= len34);

    assign pvx       = proj_b_reg ? rdata_b[63:32] : rdata_a[63:32];
    assign pvy       = proj_b_reg ? rdata_b[31:0]  : rdata_a[31:0];
    assign pv        = pmx_reg + pmy_reg;

    assign sep       = !((alo_reg <= bhi_reg) && (ahi_reg >= blo_reg));
    assign ov_hi     = (ahi_reg < bhi_reg) ? ahi_reg : bhi_reg;
    assign ov_lo     = (alo_reg > blo_reg) ? alo_reg : blo_reg;
    assign ov        = ov_hi - ov_lo;

    assign sc_c      = comp_reg ? bny_reg : bnx_reg;
    assign sc_m      = sc_c[NW-1] ? UW'(-sc_c) : UW'(sc_c);
    assign u_ov      = best_reg[PW-2:0];
    assign sc_full   = SW'(shi_reg) + SW'(slo_reg[LW-1:FRAC_BITS]);
    assign sc_r      = sc_full[SW-1:FRAC_BITS];

    always_comb
    begin
        if (sc_c[NW-1])
            sc_val = (sc_r > R_MIN_MAG) ? S32_MIN : 32'(-sc_r);
        else
            sc_val = (sc_r > R_MAX) ? S32_MAX : $signed(sc_r[31:0]);
    end

    assign dcx       = $signed({ca_x_reg[31], ca_x_reg}) - $signed({cb_x_reg[31], cb_x_reg});
    assign dcy       = $signed({ca_y_reg[31], ca_y_reg}) - $signed({cb_y_reg[31], cb_y_reg});
    assign dsum      = pdx_reg + pdy_reg;
    assign load_out  = !out_valid_reg || result.ready;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spc_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    if ((q_job.cnt_a == '0) || (q_job.cnt_b == '0))
                        state_next = spc_pkg::S_DONE;
                    else
                        state_next = spc_pkg::S_FETCH0;
                end
            end
            spc_pkg::S_FETCH0: state_next = spc_pkg::S_FETCH1;
            spc_pkg::S_FETCH1: state_next = spc_pkg::S_DIFF;
            spc_pkg::S_DIFF:
                state_next = zero_edge ? spc_pkg::S_DONE : spc_pkg::S_NORM;
            spc_pkg::S_NORM:
            begin
                if ((ax_reg[32:31] == 2'b00) && (ay_reg[32:31] == 2'b00))
                    state_next = spc_pkg::S_SQX;
            end
            spc_pkg::S_SQX:    state_next = spc_pkg::S_SQY;
            spc_pkg::S_SQY:    state_next = spc_pkg::S_SQRT;
            spc_pkg::S_SQRT:
            begin
                if (step_reg == 5'(SQ_STEPS - 1))
                    state_next = spc_pkg::S_DIV;
            end
            spc_pkg::S_DIV:
            begin
                if (step_reg == 5'(FRAC_BITS))
                    state_next = spc_pkg::S_AXIS;
            end
            spc_pkg::S_AXIS:   state_next = spc_pkg::S_PADDR;
            spc_pkg::S_PADDR:  state_next = spc_pkg::S_PMUL;
            spc_pkg::S_PMUL:   state_next = spc_pkg::S_PACC;
            spc_pkg::S_PACC:
                state_next = (proj_b_reg && proj_wrap) ? spc_pkg::S_CMP : spc_pkg::S_PADDR;
            spc_pkg::S_CMP:
            begin
                if (sep || (ov == '0))
                    state_next = spc_pkg::S_DONE;
                else if (last_axis)
                    state_next = spc_pkg::S_SCMUL;
                else
                    state_next = spc_pkg::S_FETCH0;
            end
            spc_pkg::S_SCMUL:  state_next = spc_pkg::S_SCSUM;
            spc_pkg::S_SCSUM:
                state_next = comp_reg ? spc_pkg::S_DIRMUL : spc_pkg::S_SCMUL;
            spc_pkg::S_DIRMUL: state_next = spc_pkg::S_DIR;
            spc_pkg::S_DIR:    state_next = spc_pkg::S_DONE;
            spc_pkg::S_DONE:
            begin
                if (load_out)
                    state_next = spc_pkg::S_IDLE;
            end
            default:           state_next = spc_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // State outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        q_pop = 1'b0;
        busy  = 1'b1;
        raddr = edge_idx_reg;
        case (state_reg)
            spc_pkg::S_IDLE:
            begin
                busy  = 1'b0;
                q_pop = !q_empty;
            end
            spc_pkg::S_FETCH1: raddr = j_idx;
            spc_pkg::S_PADDR:  raddr = proj_idx_reg;
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_comb
    begin
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        ovf_next        = ovf_reg;
        ca_x_next       = ca_x_reg;
        ca_y_next       = ca_y_reg;
        cb_x_next       = cb_x_reg;
        cb_y_next       = cb_y_reg;
        edge_b_next     = edge_b_reg;
        edge_idx_next   = edge_idx_reg;
        first_axis_next = first_axis_reg;
        p0_next         = p0_reg;
        dx_neg_next     = dx_neg_reg;
        dy_neg_next     = dy_neg_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        sqx_next        = sqx_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;
        step_next       = step_reg;
        drx_next        = drx_reg;
        dry_next        = dry_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        proj_b_next     = proj_b_reg;
        proj_idx_next   = proj_idx_reg;
        pmx_next        = pmx_reg;
        pmy_next        = pmy_reg;
        alo_next        = alo_reg;
        ahi_next        = ahi_reg;
        blo_next        = blo_reg;
        bhi_next        = bhi_reg;
        best_next       = best_reg;
        bnx_next        = bnx_reg;
        bny_next        = bny_reg;
        comp_next       = comp_reg;
        shi_next        = shi_reg;
        slo_next        = slo_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        pdx_next        = pdx_reg;
        pdy_next        = pdy_reg;
        hit_next        = hit_reg;
        o_hit_next      = o_hit_reg;
        o_ovf_next      = o_ovf_reg;
        o_mx_next       = o_mx_reg;
        o_my_next       = o_my_reg;

        case (state_reg)
            spc_pkg::S_IDLE:
            begin
                cnt_a_next      = CW'(q_job.cnt_a);
                cnt_b_next      = CW'(q_job.cnt_b);
                ovf_next        = q_job.ovf;
                ca_x_next       = q_job.ca_x;
                ca_y_next       = q_job.ca_y;
                cb_x_next       = q_job.cb_x;
                cb_y_next       = q_job.cb_y;
                edge_b_next     = 1'b0;
                edge_idx_next   = '0;
                first_axis_next = 1'b1;
                hit_next        = 1'b0;
                mx_next         = '0;
                my_next         = '0;
            end
            spc_pkg::S_FETCH1:
                p0_next = sel_data;
            spc_pkg::S_DIFF:
            begin
                dx_neg_next = dx[32];
                dy_neg_next = dy[32];
                ax_next     = dx_abs;
                ay_next     = dy_abs;
            end
            spc_pkg::S_NORM:
            begin
                if ((ax_reg[32:31] != 2'b00) || (ay_reg[32:31] != 2'b00))
                begin
                    ax_next = ax_reg >> 1;
                    ay_next = ay_reg >> 1;
                end
            end
            spc_pkg::S_SQX:
                sqx_next = ax_reg[30:0] * ax_reg[30:0];
            spc_pkg::S_SQY:
            begin
                rem_next  = {1'b0, sqx_reg} + {1'b0, ay_sq};
                root_next = '0;
                bit_next  = 63'(1) << 62;
                step_next = '0;
            end
            spc_pkg::S_SQRT:
            begin
                // Bit-pair square root, one result bit per cycle.
                if (rem_reg >= sq_try)
                begin
                    rem_next  = rem_reg - sq_try;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(SQ_STEPS - 1))
                begin
                    drx_next  = {1'b0, ax_reg};
                    dry_next  = {1'b0, ay_reg};
                    step_next = '0;
                end
            end
            spc_pkg::S_DIV:
            begin
                // The magnitude never exceeds the length, so the quotient
                // needs only one integer bit.
                drx_next  = bx ? tx - len34 : tx;
                dry_next  = by ? ty - len34 : ty;
                qx_next   = {qx_reg[UW-2:0], bx};
                qy_next   = {qy_reg[UW-2:0], by};
                step_next = step_reg + 5'd1;
            end
            spc_pkg::S_AXIS:
            begin
                nx_next       = dy_neg_reg ? $signed({1'b0, qy_reg}) : -$signed({1'b0, qy_reg});
                ny_next       = dx_neg_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
                proj_b_next   = 1'b0;
                proj_idx_next = '0;
            end
            spc_pkg::S_PMUL:
            begin
                pmx_next = pvx * nx_reg;
                pmy_next = pvy * ny_reg;
            end
            spc_pkg::S_PACC:
            begin
                if (!proj_b_reg)
                begin
                    if ((proj_idx_reg == '0) || (pv < alo_reg))
                        alo_next = pv;
                    if ((proj_idx_reg == '0) || (pv > ahi_reg))
                        ahi_next = pv;
                end
                else
                begin
                    if ((proj_idx_reg == '0) || (pv < blo_reg))
                        blo_next = pv;
                    if ((proj_idx_reg == '0) || (pv > bhi_reg))
                        bhi_next = pv;
                end
                if (proj_wrap)
                begin
                    proj_b_next   = 1'b1;
                    proj_idx_next = '0;
                end
                else
                begin
                    proj_idx_next = AW'(proj_inc);
                end
            end
            spc_pkg::S_CMP:
            begin
                // On a tie the earlier axis is kept.
                if (first_axis_reg || (ov < best_reg))
                begin
                    best_next = ov;
                    bnx_next  = nx_reg;
                    bny_next  = ny_reg;
                end
                first_axis_next = 1'b0;
                comp_next       = 1'b0;
                if (!edge_b_reg && edge_wrap)
                begin
                    edge_b_next   = 1'b1;
                    edge_idx_next = '0;
                end
                else
                begin
                    edge_idx_next = AW'(edge_inc);
                end
            end
            spc_pkg::S_SCMUL:
            begin
                shi_next = u_ov[PW-2:FRAC_BITS] * sc_m;
                slo_next = u_ov[FRAC_BITS-1:0] * sc_m;
            end
            spc_pkg::S_SCSUM:
            begin
                if (comp_reg)
                    my_next = sc_val;
                else
                    mx_next = sc_val;
                comp_next = 1'b1;
            end
            spc_pkg::S_DIRMUL:
            begin
                pdx_next = dcx * mx_reg;
                pdy_next = dcy * my_reg;
            end
            spc_pkg::S_DIR:
            begin
                hit_next = 1'b1;
                if (dsum < 0)
                begin
                    mx_next = neg_sat(mx_reg);
                    my_next = neg_sat(my_reg);
                end
            end
            spc_pkg::S_DONE:
            begin
                if (load_out)
                begin
                    o_hit_next = hit_reg;
                    o_ovf_next = ovf_reg;
                    o_mx_next  = hit_reg ? mx_reg : '0;
                    o_my_next  = hit_reg ? my_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if ((state_reg == spc_pkg::S_DONE) && load_out)
            out_valid_next = 1'b1;
    end

    assign result.valid      = out_valid_reg;
    assign result.intersects = o_hit_reg;
    assign result.mtv_x      = o_mx_reg;
    assign result.mtv_y      = o_my_reg;
    assign result.overflow   = o_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_a_reg      <= cnt_a_next;
        cnt_b_reg      <= cnt_b_next;
        ovf_reg        <= ovf_next;
        ca_x_reg       <= ca_x_next;
        ca_y_reg       <= ca_y_next;
        cb_x_reg       <= cb_x_next;
        cb_y_reg       <= cb_y_next;
        edge_b_reg     <= edge_b_next;
        edge_idx_reg   <= edge_idx_next;
        first_axis_reg <= first_axis_next;
        p0_reg         <= p0_next;
        dx_neg_reg     <= dx_neg_next;
        dy_neg_reg     <= dy_neg_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        sqx_reg        <= sqx_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        bit_reg        <= bit_next;
        step_reg       <= step_next;
        drx_reg        <= drx_next;
        dry_reg        <= dry_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        nx_reg         <= nx_next;
        ny_reg         <= ny_next;
        proj_b_reg     <= proj_b_next;
        proj_idx_reg   <= proj_idx_next;
        pmx_reg        <= pmx_next;
        pmy_reg        <= pmy_next;
        alo_reg        <= alo_next;
        ahi_reg        <= ahi_next;
        blo_reg        <= blo_next;
        bhi_reg        <= bhi_next;
        best_reg       <= best_next;
        bnx_reg        <= bnx_next;
        bny_reg        <= bny_next;
        comp_reg       <= comp_next;
        shi_reg        <= shi_next;
        slo_reg        <= slo_next;
        mx_reg         <= mx_next;
        my_reg         <= my_next;
        pdx_reg        <= pdx_next;
        pdy_reg        <= pdy_next;
        hit_reg        <= hit_next;
        o_hit_reg      <= o_hit_next;
        o_ovf_reg      <= o_ovf_next;
        o_mx_reg       <= o_mx_next;
        o_my_reg       <= o_my_next;
    end

    a_unit_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spc_pkg::S_AXIS) |-> ((qx_reg <= Q_ONE) && (qy_reg <= Q_ONE)))
        else $error("unit axis component above one");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !o_hit_reg) |-> ((o_mx_reg == '0) && (o_my_reg == '0)))
        else $error("translation vector not zero on a miss");
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == spc_pkg::S_FETCH0) && ($past(state_reg) == spc_pkg::S_IDLE))
        |-> ((cnt_a_reg != '0) && (cnt_b_reg != '0)))
        else $error("axis walk started on an empty polygon");

endmodule
